/* design/ooke_pkg.sv */
package ooke_pkg;

	localparam int SAMPLE_COUNT_BITS = 16;
	localparam int LIMIT_W = ((SAMPLE_COUNT_BITS > 16) ? SAMPLE_COUNT_BITS : 16) + 1;

	localparam int FRAME_LEN = 36;
	localparam int POS_W = 6;
	localparam int CHIP_W = 4;

	localparam logic [CHIP_W-1:0] SYNC_CHIPS = 4'd9;
	localparam logic [CHIP_W-1:0] ZERO_CHIPS = 4'd3;
	localparam logic [CHIP_W-1:0] ONE_CHIPS = 4'd5;

	localparam logic [3:0] CH_OFFSET = 4'd7;
	localparam logic [3:0] FILL_NIBBLE = 4'hF;

	localparam logic [0:0] REG_SAMPLES_PER_SYMBOL = 1'b0;
	localparam logic [0:0] REG_REPEAT_COUNT = 1'b1;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic kind;
		logic [7:0] sensor_id;
		logic [1:0] channel;
		logic signed [11:0] temperature;
		logic [6:0] humidity;
	} ooke_item_t;

	typedef struct packed {
		logic ook_level;
		logic active;
		logic last;
	} ooke_res_t;

endpackage

/* design/ooke_seq.sv */
module ooke_seq
	import ooke_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  ooke_item_t item,
	input  logic [15:0] samples_per_symbol,
	input  logic [7:0] repeat_count,
	output ooke_res_t res
);

	logic [FRAME_LEN-1:0] frame_q, frame_n;
	logic busy_q, busy_n;
	logic [SAMPLE_COUNT_BITS-1:0] samp_q, samp_n;
	logic [CHIP_W-1:0] chip_q, chip_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0] reps_q, reps_n;

	logic [LIMIT_W-1:0] limit;
	logic [LIMIT_W-1:0] cap;
	logic [8:0] reps_lim;
	logic [CHIP_W-1:0] chips;
	logic [POS_W-1:0] bit_idx;
	logic [3:0] ch_nib;

	always_comb begin
		cap = LIMIT_W'(1) << SAMPLE_COUNT_BITS;
		limit = (samples_per_symbol == 16'd0) ? LIMIT_W'(1) : LIMIT_W'(samples_per_symbol);
		if (limit > cap) begin
			limit = cap;
		end
		reps_lim = (repeat_count == 8'd0) ? 9'd1 : {1'b0, repeat_count};
		bit_idx = POS_W'(FRAME_LEN) - pos_q;
		if (pos_q == '0 || pos_q > POS_W'(FRAME_LEN)) begin
			chips = SYNC_CHIPS;
		end else if (frame_q[bit_idx]) begin
			chips = ONE_CHIPS;
		end else begin
			chips = ZERO_CHIPS;
		end
		ch_nib = {2'b00, item.channel} + CH_OFFSET;

		frame_n = frame_q;
		busy_n = busy_q;
		samp_n = samp_q;
		chip_n = chip_q;
		pos_n = pos_q;
		reps_n = reps_q;
		res.ook_level = 1'b0;
		res.active = busy_q;
		res.last = 1'b0;

		if (item.kind == KIND_START) begin
			if (!busy_q) begin
				frame_n = {item.sensor_id, ch_nib, item.temperature, FILL_NIBBLE,
					1'b0, item.humidity};
				busy_n = 1'b1;
				samp_n = '0;
				chip_n = '0;
				pos_n = '0;
				reps_n = '0;
			end
			res.active = 1'b1;
		end else if (busy_q) begin
			res.ook_level = (chip_q == '0);
			res.active = 1'b1;
			if (LIMIT_W'(samp_q) + LIMIT_W'(1) >= limit) begin
				samp_n = '0;
				if ({1'b0, chip_q} + 5'd1 >= {1'b0, chips}) begin
					chip_n = '0;
					if (pos_q >= POS_W'(FRAME_LEN)) begin
						pos_n = '0;
						if ({1'b0, reps_q} + 9'd1 >= reps_lim) begin
							res.last = 1'b1;
							busy_n = 1'b0;
							reps_n = '0;
						end else begin
							reps_n = reps_q + 8'd1;
						end
					end else begin
						pos_n = pos_q + POS_W'(1);
					end
				end else begin
					chip_n = chip_q + CHIP_W'(1);
				end
			end else begin
				samp_n = samp_q + SAMPLE_COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			busy_q <= 1'b0;
			samp_q <= '0;
			chip_q <= '0;
			pos_q <= '0;
			reps_q <= '0;
		end else if (take) begin
			frame_q <= frame_n;
			busy_q <= busy_n;
			samp_q <= samp_n;
			chip_q <= chip_n;
			pos_q <= pos_n;
			reps_q <= reps_n;
		end
	end

endmodule

/* design/ook_sensor_frame_encoder_top.sv */
// OOK pulse-distance frame encoder for a temperature/humidity sensor.
// Input stream (s_*): tuser selects start (0) or sample tick (1). A start beat
// packs id, channel, temperature and humidity into a 36-bit frame and arms a
// burst; a start while a burst runs is dropped. Each tick beat yields one
// output sample: sync (1 high, 8 low chips) then 36 bits MSB first, zero as
// 1 high + 2 low chips, one as 1 high + 4 low chips, each chip
// samples_per_symbol ticks, the whole sent repeat_count times.
// Output stream (m_*): one beat per input beat, ook_level and active in tdata,
// tlast on the final sample of the final repeat.
// The output is registered and shows in the cycle after its beat is taken; one
// beat per cycle is sustained while m_tready is high, set by the single counter
// update per beat. The output register frees itself in the cycle the receiver
// takes it, so a stalled receiver holds s_tready low only while a result is waiting.
// Config writes (cfg_*) are always taken: index 0 samples_per_symbol,
// index 1 repeat_count. Reset returns to idle with 1000 ticks per chip and
// 12 repeats.
module ook_sensor_frame_encoder_top
	import ooke_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // sensor_id[7:0], channel[9:8], temperature[21:10], humidity[28:22]
	input  logic [0:0] s_tuser,   // kind
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,   // ook_level[0], active[1]
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] spc_q;
	logic [7:0] rep_q;
	logic take;
	ooke_item_t item;
	ooke_res_t res, res_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready = !out_valid_q || m_tready;
	assign take = s_tvalid && s_tready;

	assign item.kind = s_tuser[0];
	assign item.sensor_id = s_tdata[7:0];
	assign item.channel = s_tdata[9:8];
	assign item.temperature = s_tdata[21:10];
	assign item.humidity = s_tdata[28:22];

	ooke_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item(item),
		.samples_per_symbol(spc_q),
		.repeat_count(rep_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= 16'd1000;
			rep_q <= 8'd12;
		end else if (cfg_valid) begin
			if (cfg_index == {7'd0, REG_SAMPLES_PER_SYMBOL}) begin
				spc_q <= cfg_data;
			end else if (cfg_index == {7'd0, REG_REPEAT_COUNT}) begin
				rep_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, res_q.active, res_q.ook_level};
	assign m_tlast = res_q.last;

endmodule

/* sim/ook_burst_checker.sv */
module ook_burst_checker
	import ooke_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [31:0] s_tdata,  // sensor_id[7:0], channel[9:8], temperature[21:10], humidity[28:22]
	input  logic [0:0] s_tuser,   // kind
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [7:0] m_tdata,   // ook_level[0], active[1]
	input  logic m_tlast,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [15:0] cfg_data,
	output int in_flight,
	output int fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] chip_ticks;
	logic [7:0] send_total;

	logic [35:0] frame_word;
	logic burst_on;
	logic [15:0] tick_in_chip;
	logic [3:0] chip_idx;
	logic [5:0] bit_idx;
	logic [7:0] sends_done;

	ooke_res_t expected_samples[$];
	int bad = 0;

	assign fail_count = bad;

	task automatic clear_position();
		burst_on = 1'b0;
		tick_in_chip = '0;
		chip_idx = '0;
		bit_idx = '0;
		sends_done = '0;
	endtask

	task automatic play_item(input logic kind, input logic [31:0] word, output ooke_res_t r);
		logic [3:0] chan_nib;
		logic [3:0] chips;
		int lim;
		int reps;
		r = '0;
		if (kind == KIND_START) begin
			if (!burst_on) begin
				chan_nib = {2'b00, word[9:8]} + CH_OFFSET;
				frame_word = {word[7:0], chan_nib, word[21:10], FILL_NIBBLE, 1'b0, word[28:22]};
				clear_position();
				burst_on = 1'b1;
			end
			r.active = burst_on;
		end else if (burst_on) begin
			lim = (chip_ticks == 0) ? 1 : int'(chip_ticks);
			reps = (send_total == 0) ? 1 : int'(send_total);
			if (bit_idx == 0 || bit_idx > FRAME_LEN)
				chips = SYNC_CHIPS;
			else
				chips = frame_word[FRAME_LEN - int'(bit_idx)] ? ONE_CHIPS : ZERO_CHIPS;
			r.ook_level = (chip_idx == 0);
			r.active = 1'b1;
			if (int'(tick_in_chip) + 1 >= lim) begin
				tick_in_chip = '0;
				if (int'(chip_idx) + 1 >= int'(chips)) begin
					chip_idx = '0;
					if (bit_idx >= FRAME_LEN) begin
						bit_idx = '0;
						if (int'(sends_done) + 1 >= reps) begin
							r.last = 1'b1;
							clear_position();
						end else begin
							sends_done = sends_done + 8'd1;
						end
					end else begin
						bit_idx = bit_idx + 6'd1;
					end
				end else begin
					chip_idx = chip_idx + 4'd1;
				end
			end else begin
				tick_in_chip = tick_in_chip + 16'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		ooke_res_t want;
		ooke_res_t got;
		if (!arst_n) begin
			chip_ticks = 16'd1000;
			send_total = 8'd12;
			frame_word = '0;
			clear_position();
			expected_samples.delete();
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 8'(REG_SAMPLES_PER_SYMBOL))
					chip_ticks = cfg_data;
				else if (cfg_index == 8'(REG_REPEAT_COUNT))
					send_total = cfg_data[7:0];
			end
			if (s_tvalid && s_tready) begin
				play_item(s_tuser[0], s_tdata, want);
				expected_samples.insert(expected_samples.size(), want);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[1], m_tlast};
				if (expected_samples.size() == 0) begin
					$error("output beat with nothing expected: ook_level %0b active %0b last %0b",
						got.ook_level, got.active, got.last);
					bad++;
				end else begin
					want = expected_samples.pop_front();
					if (got.ook_level !== want.ook_level) begin
						$error("ook_level: expected %0b, got %0b", want.ook_level, got.ook_level);
						bad++;
					end
					if (got.active !== want.active) begin
						$error("active: expected %0b, got %0b", want.active, got.active);
						bad++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, got.last);
						bad++;
					end
				end
			end
			in_flight <= expected_samples.size();
		end
	end

endmodule

/* sim/ook_sensor_frame_encoder_top_tb.sv */
module ook_sensor_frame_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ooke_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_BEATS = 1300;
	localparam int HOLD_CYCLES = 200;
	localparam int TICK_CAP = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0] s_tuser = KIND_TICK;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int in_flight;
	int fail_count;

	bit tx_eager = 1'b0;
	bit rx_eager = 1'b0;
	bit rx_hold_req = 1'b0;
	int cycles = 0;
	int n_beats = 0;
	int n_starts = 0;
	int n_ticks = 0;
	int n_writes = 0;
	int n_holds = 0;
	int lasts_seen = 0;

	ook_sensor_frame_encoder_top uut (.*);
	ook_burst_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom();
		w[31:29] = 3'b000;
		return w;
	endfunction

	function automatic logic [31:0] pack_reading(input logic [7:0] id, input logic [1:0] ch,
			input logic [11:0] temp, input logic [6:0] hum);
		return {3'b000, hum, temp, ch, id};
	endfunction

	task automatic send_beat(input logic kind, input logic [31:0] word);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		n_beats++;
		if (kind == KIND_START)
			n_starts++;
		else
			n_ticks++;
	endtask

	// drop valid and wait until every sent beat has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic write_regs(input logic [15:0] ticks, input logic [7:0] sends);
		cfg_valid <= 1'b1;
		cfg_index <= 8'(REG_SAMPLES_PER_SYMBOL);
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= 8'(REG_REPEAT_COUNT);
		cfg_data <= {8'h00, sends};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes += 2;
	endtask

	// tick until the burst ends or TICK_CAP beats are sent, with an occasional stray start
	task automatic play_out();
		int goal;
		int n;
		goal = lasts_seen + 1;
		n = 0;
		while (lasts_seen < goal && n < TICK_CAP) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(KIND_START, random_word());
			else
				send_beat(KIND_TICK, random_word());
			n++;
		end
	endtask

	task automatic run_sequence(input bit complete_ok);
		int pick;
		pick = $urandom_range(0, 99);
		if (complete_ok && pick < 70) begin
			send_beat(KIND_START, random_word());
			play_out();
		end else if (pick < 85) begin
			send_beat(KIND_START, random_word());
			repeat ($urandom_range(1, 40)) send_beat(KIND_TICK, random_word());
		end else begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 1) == 0)
					send_beat(KIND_TICK, random_word());
				else
					send_beat(KIND_START, random_word());
			end
		end
	endtask

	initial begin : rx
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = rx_eager ? 0 : $urandom_range(0, 13);
			if (rx_hold_req) begin
				stall = HOLD_CYCLES;
				rx_hold_req = 1'b0;
				n_holds++;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (m_tlast)
				lasts_seen++;
		end
	end

	initial begin : stim
		int phase;
		int sel;
		logic [15:0] ticks;
		logic [7:0] sends;
		do @(posedge clk); while (!arst_n);

		send_beat(KIND_TICK, 32'h1FFF_FFFF);
		send_beat(KIND_TICK, 32'h0000_0000);
		send_beat(KIND_START, pack_reading(8'hFF, 2'd3, 12'h800, 7'h7F));
		send_beat(KIND_START, pack_reading(8'h00, 2'd0, 12'h000, 7'h00));
		repeat (3) send_beat(KIND_TICK, random_word());
		settle();
		write_regs(16'd1, 8'd0);
		play_out();
		settle();
		write_regs(16'd0, 8'd1);
		send_beat(KIND_START, pack_reading(8'h00, 2'd0, 12'h000, 7'h00));
		play_out();
		settle();
		write_regs(16'hFFFF, 8'hFF);
		send_beat(KIND_START, pack_reading(8'hA5, 2'd1, 12'h7FF, 7'd100));
		repeat (4) send_beat(KIND_TICK, random_word());
		settle();
		write_regs(16'd1, 8'd1);
		play_out();

		phase = 0;
		while (n_beats < RANDOM_BEATS) begin
			settle();
			sel = $urandom_range(0, 9);
			ticks = (sel < 1) ? 16'd0 : (sel < 6) ? 16'd1 : (sel < 8) ? 16'd2 :
				(sel < 9) ? 16'd3 : 16'hFFFF;
			sel = $urandom_range(0, 9);
			sends = (sel < 1) ? 8'd0 : (sel < 7) ? 8'd1 : (sel < 9) ? 8'd2 : 8'hFF;
			write_regs(ticks, sends);
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager = ($urandom_range(0, 3) == 0);
			if (phase == 0 || phase == 4) begin
				tx_eager = 1'b1;
				rx_eager = 1'b0;
				rx_hold_req = 1'b1;
				repeat (8) send_beat(KIND_TICK, random_word());
			end
			repeat ($urandom_range(1, 2)) run_sequence(ticks < 16'd4 && sends < 8'd3);
			phase++;
		end

		settle();
		repeat (4) @(posedge clk);
		$display("Covered %0d beats (%0d starts, %0d ticks), %0d bursts ended on tlast.",
			n_beats, n_starts, n_ticks, lasts_seen);
		$display("%0d register writes over %0d phases, %0d long output stalls, %0d mismatches.",
			n_writes, phase, n_holds, fail_count);
		if (fail_count == 0 && in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
